FILE: rtl/cfsk_pkg.sv
// cfsk_pkg: shared types, constants and the sine table for the cassette fsk generator
// no dependencies; imported by cfsk_core and the top level
package cfsk_pkg;

  localparam int unsigned DataW   = 8;
  localparam int unsigned CountW  = 24;
  localparam int unsigned RemainW = CountW + 1;
  localparam int unsigned PhaseW  = 6;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned PulseW  = 3;

  localparam logic [PhaseW-1:0] TableLen   = PhaseW'(36);
  localparam logic [SlotW-1:0]  StopSlot   = SlotW'(9);
  localparam logic [PulseW-1:0] StopPulses = PulseW'(4);
  localparam logic [DataW-1:0]  ZeroLevel  = DataW'(128);

  // command codes carried in the input tuser
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_BYTE    = 2'd1,
    OP_HEADER  = 2'd2,
    OP_SILENCE = 2'd3
  } op_t;

  // one input beat, unpacked
  typedef struct packed {
    op_t               op;
    logic [DataW-1:0]  data_byte;
    logic [CountW-1:0] count;
  } cmd_t;

  // one result from the sample engine
  typedef struct packed {
    logic             valid;
    logic [DataW-1:0] sample;
    logic             last;
  } res_t;

  // one sine period, 128 + trunc(127*sin(2*pi*k/36))
  function automatic logic [DataW-1:0] sine_lookup(input logic [PhaseW-1:0] idx);
    logic [DataW-1:0] v;
    case (idx)
      6'd0:  v = 8'd128;  6'd1:  v = 8'd150;  6'd2:  v = 8'd171;
      6'd3:  v = 8'd191;  6'd4:  v = 8'd209;  6'd5:  v = 8'd225;
      6'd6:  v = 8'd237;  6'd7:  v = 8'd247;  6'd8:  v = 8'd253;
      6'd9:  v = 8'd255;  6'd10: v = 8'd253;  6'd11: v = 8'd247;
      6'd12: v = 8'd237;  6'd13: v = 8'd225;  6'd14: v = 8'd209;
      6'd15: v = 8'd191;  6'd16: v = 8'd171;  6'd17: v = 8'd150;
      6'd18: v = 8'd128;  6'd19: v = 8'd106;  6'd20: v = 8'd85;
      6'd21: v = 8'd65;   6'd22: v = 8'd47;   6'd23: v = 8'd31;
      6'd24: v = 8'd19;   6'd25: v = 8'd9;    6'd26: v = 8'd3;
      6'd27: v = 8'd1;    6'd28: v = 8'd3;    6'd29: v = 8'd9;
      6'd30: v = 8'd19;   6'd31: v = 8'd31;   6'd32: v = 8'd47;
      6'd33: v = 8'd65;   6'd34: v = 8'd85;   6'd35: v = 8'd106;
      default: v = ZeroLevel;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/cfsk_core.sv
// cfsk_core: command state and per-tick sample computation, one command per cycle while step_en is high
// depends on cfsk_pkg
module cfsk_core import cfsk_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic baud_select,
  input  logic step_en,
  input  cmd_t cmd,
  output res_t res
);

  typedef enum logic [1:0] {
    ACT_IDLE    = 2'd0,
    ACT_BYTE    = 2'd1,
    ACT_HEADER  = 2'd2,
    ACT_SILENCE = 2'd3
  } activity_t;

  activity_t          activity, activity_next;
  logic [DataW-1:0]   shift_byte, shift_byte_next;
  logic [SlotW-1:0]   bit_slot, bit_slot_next;
  logic [PulseW-1:0]  pulse_in_slot, pulse_in_slot_next;
  logic [PhaseW-1:0]  phase_index, phase_index_next;
  logic [RemainW-1:0] remaining, remaining_next;

  logic [PhaseW-1:0]  idx;
  logic [DataW-1:0]   tbl;
  logic               is_short;
  logic [2:0]         step;
  logic [PhaseW:0]    sum;
  logic               pulse_end;
  logic [PulseW-1:0]  needed;
  logic [PulseW-1:0]  pulse_inc;
  logic [SlotW-1:0]   slot_inc;
  logic [RemainW-1:0] remain_dec;

  // table position, step size and pulse end
  always_comb begin
    idx = (phase_index >= TableLen) ? '0 : phase_index;
    tbl = sine_lookup(idx);
    if (bit_slot == '0) begin
      is_short = 1'b0;
    end else if (bit_slot >= StopSlot) begin
      is_short = 1'b1;
    end else begin
      is_short = shift_byte[0];
    end
    if (activity == ACT_HEADER || is_short) begin
      step = baud_select ? 3'd4 : 3'd2;
    end else begin
      step = baud_select ? 3'd2 : 3'd1;
    end
    sum        = {1'b0, idx} + (PhaseW+1)'(step);
    pulse_end  = sum >= {1'b0, TableLen};
    needed     = !is_short ? PulseW'(1) : ((bit_slot >= StopSlot) ? StopPulses : PulseW'(2));
    pulse_inc  = pulse_in_slot + PulseW'(1);
    slot_inc   = bit_slot + SlotW'(1);
    remain_dec = (remaining != '0) ? remaining - RemainW'(1) : remaining;
  end

  // command load and tick handling
  always_comb begin
    activity_next      = activity;
    shift_byte_next    = shift_byte;
    bit_slot_next      = bit_slot;
    pulse_in_slot_next = pulse_in_slot;
    phase_index_next   = phase_index;
    remaining_next     = remaining;
    res                = '0;
    res.sample         = ZeroLevel;
    if (step_en) begin
      if (cmd.op != OP_TICK) begin
        // load only when idle
        if (activity == ACT_IDLE) begin
          phase_index_next   = '0;
          pulse_in_slot_next = '0;
          bit_slot_next      = '0;
          if (cmd.op == OP_BYTE) begin
            shift_byte_next = cmd.data_byte;
            activity_next   = ACT_BYTE;
          end else if (cmd.count != '0) begin
            if (cmd.op == OP_HEADER) begin
              remaining_next = {1'b0, cmd.count} << baud_select;
              activity_next  = ACT_HEADER;
            end else begin
              remaining_next = {1'b0, cmd.count};
              activity_next  = ACT_SILENCE;
            end
          end
        end
      end else if (activity != ACT_IDLE) begin
        res.valid = 1'b1;
        unique case (activity)
          ACT_SILENCE: begin
            remaining_next = remain_dec;
            if (remain_dec == '0) begin
              res.last      = 1'b1;
              activity_next = ACT_IDLE;
            end
          end
          ACT_HEADER: begin
            res.sample       = tbl;
            phase_index_next = pulse_end ? '0 : sum[PhaseW-1:0];
            if (pulse_end) begin
              remaining_next = remain_dec;
              if (remain_dec == '0) begin
                res.last      = 1'b1;
                activity_next = ACT_IDLE;
              end
            end
          end
          ACT_BYTE: begin
            res.sample       = tbl;
            phase_index_next = pulse_end ? '0 : sum[PhaseW-1:0];
            if (pulse_end) begin
              if (pulse_inc >= needed) begin
                pulse_in_slot_next = '0;
                if (bit_slot != '0 && bit_slot < StopSlot) begin
                  shift_byte_next = shift_byte >> 1;
                end
                if (slot_inc > StopSlot) begin
                  bit_slot_next = '0;
                  res.last      = 1'b1;
                  activity_next = ACT_IDLE;
                end else begin
                  bit_slot_next = slot_inc;
                end
              end else begin
                pulse_in_slot_next = pulse_inc;
              end
            end
          end
          default: res.valid = 1'b0;
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      activity      <= ACT_IDLE;
      shift_byte    <= '0;
      bit_slot      <= '0;
      pulse_in_slot <= '0;
      phase_index   <= '0;
      remaining     <= '0;
    end else begin
      activity      <= activity_next;
      shift_byte    <= shift_byte_next;
      bit_slot      <= bit_slot_next;
      pulse_in_slot <= pulse_in_slot_next;
      phase_index   <= phase_index_next;
      remaining     <= remaining_next;
    end
  end

`ifndef SYNTHESIS
  // table position never leaves the period
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase_index < TableLen)
    else $error("phase index out of range");

  // byte framing never runs past the stop slot
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    bit_slot <= StopSlot && pulse_in_slot < StopPulses)
    else $error("bit slot or pulse count out of range");

  // a tick while idle gives no sample
  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    step_en && cmd.op == OP_TICK && activity == ACT_IDLE |-> !res.valid)
    else $error("sample produced while idle");

  // an active silence or header always has a count left
  a_remaining: assert property (@(posedge clk) disable iff (rst)
    (activity == ACT_SILENCE || activity == ACT_HEADER) |-> remaining != '0)
    else $error("active command with nothing remaining");

  // a final sample always returns the engine to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.last |=> activity == ACT_IDLE)
    else $error("last sample did not end the command");
`endif

endmodule

FILE: rtl/cassette_fsk_sample_generator_unit.sv
// cassette fsk sample generator: input beat register, sample engine, output register
// a tick beat is held in the input beat register, then its sample is registered in the output register for m_tvalid
// throughput: one beat per cycle in and one sample per cycle out while m_tready does not hold the output,
//   set by the single engine pass between the input register and the output register
// reset (rst, synchronous): engine idle, both registers empty, no input beat taken,
//   baud select back to 0
// depends on cfsk_pkg and cfsk_core
module cassette_fsk_sample_generator_unit import cfsk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic        cfg_wdata,   // baud_select
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,     // data_byte [7:0], count [31:8]
  input  logic [1:0]  s_tuser,     // operation [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,     // sample [7:0]
  output logic        m_tlast
);

  logic baud_select;
  logic in_valid;
  cmd_t in_cmd;
  logic step_en;
  res_t res;
  logic [DataW-1:0] out_sample;
  logic out_last;
  logic out_valid;

  // the input beat moves on when the output slot is free or draining
  assign step_en  = in_valid && (!out_valid || m_tready);
  assign s_tready = !rst && (!in_valid || step_en);

  // baud select register
  always_ff @(posedge clk) begin
    if (rst) begin
      baud_select <= 1'b0;
    end else if (cfg_wen) begin
      baud_select <= cfg_wdata;
    end
  end

  // input beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_cmd.op        <= op_t'(s_tuser);
      in_cmd.data_byte <= s_tdata[DataW-1:0];
      in_cmd.count     <= s_tdata[DataW+CountW-1:DataW];
    end
  end

  cfsk_core u_core (
    .clk         (clk),
    .rst         (rst),
    .baud_select (baud_select),
    .step_en     (step_en),
    .cmd         (in_cmd),
    .res         (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_en) begin
      out_valid <= res.valid;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (step_en && res.valid) begin
      out_sample <= res.sample;
      out_last   <= res.last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_sample;
  assign m_tlast  = out_last;

endmodule
